@@ sv/clnw_pkg.sv @@
// shared types, codes and constants of the character lcd nibble writer
package clnw_pkg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [16:0] value;
        logic        row;
        logic [5:0]  col;
    } cmd_beat_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       register_select;
        logic       backlight;
        logic       led_level;
        logic       last;
    } bus_beat_t;

    localparam logic [2:0] OP_COMMAND    = 3'd0;
    localparam logic [2:0] OP_CHARACTER  = 3'd1;
    localparam logic [2:0] OP_POSITIONED = 3'd2;
    localparam logic [2:0] OP_NUMBER     = 3'd3;
    localparam logic [2:0] OP_LAMPS      = 3'd4;

    typedef enum logic [2:0] {
        JOB_COMMAND,
        JOB_CHARACTER,
        JOB_POSITIONED,
        JOB_NUMBER,
        JOB_LAMPS
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  pos_byte;
        logic [7:0]  data_byte;
        logic [16:0] number;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [7:0]  POS_TOP        = 8'h80;
    localparam logic [7:0]  POS_BOTTOM     = 8'hC0;
    localparam logic [7:0]  CHAR_ZERO      = 8'h30;
    localparam logic [7:0]  CHAR_BLANK     = 8'h20;
    localparam logic [7:0]  LCD_ENTRY_MODE = 8'h06;
    localparam logic [16:0] NUM_MAX        = 17'd99999;

    localparam logic [3:0] NIBBLES_BYTE     = 4'd2;
    localparam logic [3:0] NIBBLES_POSITION = 4'd4;
    localparam logic [3:0] NIBBLES_NUMBER   = 4'd12;

    localparam logic [2:0] LAST_DIGIT = 3'd4;

    function automatic logic [3:0] nibble_count(input job_kind_t kind);
        logic [3:0] n;
        unique case (kind)
            JOB_POSITIONED: n = NIBBLES_POSITION;
            JOB_NUMBER:     n = NIBBLES_NUMBER;
            default:        n = NIBBLES_BYTE;
        endcase
        return n;
    endfunction

    function automatic logic [16:0] digit_weight(input logic [2:0] d);
        logic [16:0] w;
        unique case (d)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            default: w = 17'd1;
        endcase
        return w;
    endfunction

endpackage

@@ sv/clnw_front.sv @@
// request front end: accepts beats, drops unknown operations, builds jobs
module clnw_front
(
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  clnw_pkg::cmd_beat_t   cmd,
    output logic                  job_valid,
    input  logic                  job_ready,
    output clnw_pkg::job_t        job
);

    logic known;

    always_comb
    begin
        known          = 1'b1;
        job.kind       = clnw_pkg::JOB_COMMAND;
        job.pos_byte   = (cmd.row ? clnw_pkg::POS_BOTTOM : clnw_pkg::POS_TOP) | {2'b00, cmd.col};
        job.data_byte  = cmd.value[7:0];
        job.number     = (cmd.value > clnw_pkg::NUM_MAX) ? clnw_pkg::NUM_MAX : cmd.value;
        unique case (cmd.operation)
            clnw_pkg::OP_COMMAND:    job.kind = clnw_pkg::JOB_COMMAND;
            clnw_pkg::OP_CHARACTER:  job.kind = clnw_pkg::JOB_CHARACTER;
            clnw_pkg::OP_POSITIONED: job.kind = clnw_pkg::JOB_POSITIONED;
            clnw_pkg::OP_NUMBER:     job.kind = clnw_pkg::JOB_NUMBER;
            clnw_pkg::OP_LAMPS:
            begin
                job.kind      = clnw_pkg::JOB_LAMPS;
                job.data_byte = clnw_pkg::LCD_ENTRY_MODE;
                job.number    = {15'd0, cmd.value[1:0]};
            end
            default:                 known = 1'b0;
        endcase
    end

    // unknown operations are taken and dropped
    assign cmd_ready = job_ready;
    assign job_valid = cmd_valid && known;

endmodule

@@ sv/clnw_queue.sv @@
// job queue between front end and nibble sequencer
module clnw_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  clnw_pkg::job_t           push_job,
    output logic                     pop_valid,
    input  logic                     pop_ready,
    output clnw_pkg::job_t           pop_job,
    output clnw_pkg::queue_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    clnw_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready   = (count_reg != CNT_FULL);
    assign pop_valid    = (count_reg != '0);
    assign push         = push_valid && push_ready;
    assign pop          = pop_valid && pop_ready;
    assign pop_job      = mem[rd_ptr_reg];
    assign status.full  = !push_ready;
    assign status.empty = !pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ sv/clnw_back.sv @@
// nibble sequencer: walks each job byte by byte and drives the output register
module clnw_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  clnw_pkg::job_t       job,
    output logic                 bus_valid,
    input  logic                 bus_ready,
    output clnw_pkg::bus_beat_t  bus
);

    clnw_pkg::job_t      cur_reg, cur_next;
    logic                busy_reg, busy_next;
    logic [3:0]          idx_reg, idx_next;
    logic [16:0]         rem_reg, rem_next;
    logic                shown_reg, shown_next;
    logic                led_reg, led_next;
    logic                light_reg, light_next;
    logic                bus_valid_reg, bus_valid_next;
    clnw_pkg::bus_beat_t bus_reg, bus_next;

    logic        emit, last_nib, take;
    logic [2:0]  byte_idx, digit_sel;
    logic [16:0] weight, sub;
    logic [16:0] thr [1:9];
    logic [3:0]  digit;
    logic        blank;
    logic [7:0]  digit_byte, cur_byte;
    logic        rs;

    assign emit      = busy_reg && (!bus_valid_reg || bus_ready);
    assign last_nib  = (idx_reg == clnw_pkg::nibble_count(cur_reg.kind) - 4'd1);
    assign take      = !busy_reg || (emit && last_nib);
    assign job_ready = take;
    assign byte_idx  = idx_reg[3:1];
    assign digit_sel = byte_idx - 3'd1;
    assign weight    = clnw_pkg::digit_weight(digit_sel);

    // one decimal digit of the remainder
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int k = 1; k <= 9; k++)
        begin
            thr[k] = 17'(32'(weight) * k);
            if (rem_reg >= thr[k])
            begin
                digit = 4'(k);
                sub   = thr[k];
            end
        end
        blank      = (digit == 4'd0) && !shown_reg && (digit_sel != clnw_pkg::LAST_DIGIT);
        digit_byte = blank ? clnw_pkg::CHAR_BLANK : (clnw_pkg::CHAR_ZERO | {4'd0, digit});
    end

    always_comb
    begin
        cur_byte = cur_reg.data_byte;
        rs       = 1'b1;
        unique case (cur_reg.kind)
            clnw_pkg::JOB_COMMAND,
            clnw_pkg::JOB_LAMPS:
            begin
                rs = 1'b0;
            end
            clnw_pkg::JOB_CHARACTER:
            begin
                rs = 1'b1;
            end
            clnw_pkg::JOB_POSITIONED:
            begin
                cur_byte = (byte_idx == 3'd0) ? cur_reg.pos_byte : cur_reg.data_byte;
                rs       = (byte_idx != 3'd0);
            end
            clnw_pkg::JOB_NUMBER:
            begin
                cur_byte = (byte_idx == 3'd0) ? cur_reg.pos_byte : digit_byte;
                rs       = (byte_idx != 3'd0);
            end
            default:
            begin
                rs = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        shown_next     = shown_reg;
        led_next       = led_reg;
        light_next     = light_reg;
        bus_valid_next = bus_valid_reg;
        bus_next       = bus_reg;

        if (emit)
        begin
            bus_valid_next           = 1'b1;
            bus_next.nibble          = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
            bus_next.register_select = rs;
            bus_next.backlight       = light_reg;
            bus_next.led_level       = led_reg;
            bus_next.last            = last_nib;
            idx_next                 = idx_reg + 4'd1;
            if (cur_reg.kind == clnw_pkg::JOB_NUMBER && idx_reg[0] && byte_idx != 3'd0)
            begin
                rem_next   = rem_reg - sub;
                shown_next = shown_reg || !blank;
            end
        end
        else if (bus_ready)
        begin
            bus_valid_next = 1'b0;
        end

        if (take)
        begin
            busy_next = job_valid;
            if (job_valid)
            begin
                cur_next   = job;
                idx_next   = '0;
                rem_next   = job.number;
                shown_next = 1'b0;
                if (job.kind == clnw_pkg::JOB_LAMPS)
                begin
                    led_next   = job.number[0];
                    light_next = job.number[1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            shown_reg     <= 1'b0;
            led_reg       <= 1'b0;
            light_reg     <= 1'b0;
            bus_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            shown_reg     <= shown_next;
            led_reg       <= led_next;
            light_reg     <= light_next;
            bus_valid_reg <= bus_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        bus_reg <= bus_next;
    end

    assign bus_valid = bus_valid_reg;
    assign bus       = bus_reg;

endmodule

@@ sv/char_lcd_nibble_writer.sv @@
// top level of the character lcd nibble writer
//
//  channel | direction | handshake            | beat
//  cmd     | in        | cmd_valid/cmd_ready  | operation, value, row, col
//  bus     | out       | bus_valid/bus_ready  | nibble, register_select, backlight, led_level, last
//
// one nibble leaves per cycle while the bus is ready: 2 nibbles for command, character and lamps,
// 4 for a positioned character, 12 for a number; the sequencer's nibble step sets this
// a new request is taken every cycle while the job queue has room
// reset clears the queue, the sequencer and both lamp flags
// a stalled bus holds the output register; the queue absorbs requests meanwhile
module char_lcd_nibble_writer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  clnw_pkg::cmd_beat_t  cmd,
    output logic                 bus_valid,
    input  logic                 bus_ready,
    output clnw_pkg::bus_beat_t  bus
);

    logic                    fe_valid, fe_ready;
    clnw_pkg::job_t          fe_job;
    logic                    job_valid, job_ready;
    clnw_pkg::job_t          job;
    clnw_pkg::queue_status_t q_status;

    clnw_front u_front
    (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .job_valid (fe_valid),
        .job_ready (fe_ready),
        .job       (fe_job)
    );

    clnw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_job   (fe_job),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_job    (job),
        .status     (q_status)
    );

    clnw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .bus_valid (bus_valid),
        .bus_ready (bus_ready),
        .bus       (bus)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_lamps_within_request: assert property (@(posedge clk) disable iff (!rst_n)
        (bus_valid && bus_ready && !bus.last) |=>
        (!bus_valid || (bus.backlight == $past(bus.backlight)
                        && bus.led_level == $past(bus.led_level))))
        else $error("lamp flags changed inside a request");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !(job_valid && job_ready))
        else $error("job taken from empty queue");

endmodule
